[hw/rtl/ies_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ies_pkg: informed ellipse sampler shared definitions
// Widths, register codes and the types that pass between the sampler's parts.
// ----------------------------------------------------------------------------
package ies_pkg;

  // Field formats
  localparam int CoordBits  = 24;               // Q16.8 coordinates and costs
  localparam int RandBits   = 16;               // Q1.15 random numbers
  localparam int UnitFrac   = 16;               // fraction bits of the direction
  localparam int CfgIdxBits = 3;

  // Derived widths
  localparam int DeltaBits  = CoordBits + 1;    // start-goal difference, scaled axes
  localparam int DsqBits    = 2 * DeltaBits;    // squared distance
  localparam int DistBits   = DeltaBits;        // floored distance
  localparam int UnitBits   = UnitFrac + 2;     // signed direction, holds +-1.0
  localparam int CostSqBits = 2 * CoordBits;
  localparam int RootBits   = CoordBits;        // minor axis
  localparam int ProdBits   = DeltaBits + UnitBits;
  localparam int SumBits    = ProdBits + 2 - UnitFrac;
  localparam int FifoDepth  = 4;

  localparam logic [UnitBits-1:0]  UnitOne     = UnitBits'(1) << UnitFrac;
  localparam logic [CoordBits-1:0] MarginReset = CoordBits'(25600);

  // Register map
  typedef enum logic [CfgIdxBits-1:0] {
    RegStartX = 3'd0,
    RegStartY = 3'd1,
    RegGoalX  = 3'd2,
    RegGoalY  = 3'd3,
    RegInfEn  = 3'd4,
    RegMargin = 3'd5
  } cfg_reg_e;

  // Geometry derived from the registers, with the recompute status
  typedef struct packed {
    logic                        busy;
    logic [DsqBits-1:0]          dsq;
    logic [DistBits-1:0]         dlen;
    logic signed [UnitBits-1:0]  ux;
    logic signed [UnitBits-1:0]  uy;
    logic signed [CoordBits-1:0] mid_x;
    logic signed [CoordBits-1:0] mid_y;
    logic                        inf_en;
    logic [CoordBits-1:0]        margin;
  } ies_geom_t;

  // One classified transaction between front and back
  typedef struct packed {
    logic [CostSqBits-1:0]        cost_sq;
    logic signed [DeltaBits-1:0]  pa;
    logic signed [RandBits-1:0]   rand_v;
    logic                         move_now;
  } ies_item_t;

endpackage
`default_nettype wire

[hw/rtl/ies_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ies_if: sampler channels
// Valid/ready channels for the sample request and the sample result.
// ----------------------------------------------------------------------------
interface ies_in_if;
  import ies_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CoordBits-1:0]       best_cost;
  logic signed [RandBits-1:0] rand_u;
  logic signed [RandBits-1:0] rand_v;

  modport source (output valid, best_cost, rand_u, rand_v, input ready);
  modport sink   (input valid, best_cost, rand_u, rand_v, output ready);
endinterface

interface ies_out_if;
  import ies_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] sample_x;
  logic signed [CoordBits-1:0] sample_y;
  logic                        move_now;
  logic                        cost_below_distance;

  modport source (output valid, sample_x, sample_y, move_now, cost_below_distance,
                  input ready);
  modport sink   (input valid, sample_x, sample_y, move_now, cost_below_distance,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/ies_geom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ies_geom: configuration registers and ellipse geometry
// Holds the registers and, after each write, recomputes distance, unit
// direction and midpoint with a shared one-bit-per-cycle root/divide unit.
// ----------------------------------------------------------------------------
module ies_geom (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ies_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [ies_pkg::CoordBits-1:0]   cfg_data_i,
  output ies_pkg::ies_geom_t                   geom_o
);
  import ies_pkg::*;

  localparam int CntBits = $clog2(DistBits + 1);

  typedef enum logic [2:0] {
    StIdle, StDelta, StSquare, StSum, StRoot, StDivX, StDivY
  } state_e;

  state_e state_q;

  logic signed [CoordBits-1:0] sx_q, sy_q, gx_q, gy_q;
  logic                        en_q;
  logic [CoordBits-1:0]        margin_q;

  logic signed [DeltaBits-1:0] dx_q, dy_q;
  logic [DeltaBits-1:0]        ax_q, ay_q;
  logic [DsqBits-1:0]          sqx_q, sqy_q, dsq_q;
  logic [DistBits-1:0]         dist_q;
  logic signed [UnitBits-1:0]  ux_q, uy_q;
  logic signed [CoordBits-1:0] mid_x_q, mid_y_q;

  logic [DsqBits-1:0]    rt_rad_q;
  logic [DistBits+1:0]   rt_rem_q;
  logic [DistBits-1:0]   rt_root_q;
  logic [CntBits-1:0]    cnt_q;
  logic [DistBits-1:0]   dv_rem_q;
  logic [UnitBits-1:0]   dv_low_q;
  logic [UnitBits-1:0]   dv_quo_q;

  // Root step: bring down one bit pair, try to set the next root bit
  logic [DistBits+3:0] rt_rn, rt_trial;
  logic                rt_ge;
  logic [DistBits+1:0] rt_rem_nx;
  logic [DistBits-1:0] rt_root_nx;

  assign rt_rn      = {rt_rem_q, rt_rad_q[DsqBits-1 -: 2]};
  assign rt_trial   = {2'b00, rt_root_q, 2'b01};
  assign rt_ge      = (rt_rn >= rt_trial);
  assign rt_rem_nx  = rt_ge ? (DistBits+2)'(rt_rn - rt_trial) : rt_rn[DistBits+1:0];
  assign rt_root_nx = {rt_root_q[DistBits-2:0], rt_ge};

  // Divide step: one quotient bit of |delta| * 2^16 / dist
  logic [DistBits:0]   dv_rn;
  logic                dv_ge;
  logic [DistBits-1:0] dv_rem_nx;
  logic [UnitBits-1:0] dv_quo_nx, dv_clamp;

  assign dv_rn     = {dv_rem_q, dv_low_q[UnitBits-1]};
  assign dv_ge     = (dv_rn >= {1'b0, dist_q});
  assign dv_rem_nx = dv_ge ? DistBits'(dv_rn - {1'b0, dist_q}) : DistBits'(dv_rn);
  assign dv_quo_nx = {dv_quo_q[UnitBits-2:0], dv_ge};
  assign dv_clamp  = (dv_quo_nx > UnitOne) ? UnitOne : dv_quo_nx;

  // Dividend split for the divide set-up of either axis
  logic [DeltaBits+UnitFrac-1:0] dvd_x, dvd_y;
  assign dvd_x = {ax_q, {UnitFrac{1'b0}}};
  assign dvd_y = {ay_q, {UnitFrac{1'b0}}};

  logic last_root, last_div;
  assign last_root = (cnt_q == CntBits'(DistBits - 1));
  assign last_div  = (cnt_q == CntBits'(UnitBits - 1));

  // Registers, sequencer and derived results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      sx_q      <= '0;
      sy_q      <= '0;
      gx_q      <= '0;
      gy_q      <= '0;
      en_q      <= 1'b0;
      margin_q  <= MarginReset;
      dsq_q     <= '0;
      dist_q    <= '0;
      ux_q      <= signed'(UnitOne);
      uy_q      <= '0;
      mid_x_q   <= '0;
      mid_y_q   <= '0;
      cnt_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegStartX: sx_q     <= cfg_data_i;
        RegStartY: sy_q     <= cfg_data_i;
        RegGoalX:  gx_q     <= cfg_data_i;
        RegGoalY:  gy_q     <= cfg_data_i;
        RegInfEn:  en_q     <= cfg_data_i[0];
        RegMargin: margin_q <= cfg_data_i;
        default: ;
      endcase
      state_q <= StDelta;
    end else begin
      unique case (state_q)
        StIdle: ;
        StDelta: begin
          dx_q    <= {gx_q[CoordBits-1], gx_q} - {sx_q[CoordBits-1], sx_q};
          dy_q    <= {gy_q[CoordBits-1], gy_q} - {sy_q[CoordBits-1], sy_q};
          mid_x_q <= CoordBits'(({gx_q[CoordBits-1], gx_q} + {sx_q[CoordBits-1], sx_q})
                     >>> 1);
          mid_y_q <= CoordBits'(({gy_q[CoordBits-1], gy_q} + {sy_q[CoordBits-1], sy_q})
                     >>> 1);
          state_q <= StSquare;
        end
        StSquare: begin
          sqx_q   <= unsigned'(DsqBits'(dx_q) * DsqBits'(dx_q));
          sqy_q   <= unsigned'(DsqBits'(dy_q) * DsqBits'(dy_q));
          ax_q    <= dx_q[DeltaBits-1] ? unsigned'(-dx_q) : unsigned'(dx_q);
          ay_q    <= dy_q[DeltaBits-1] ? unsigned'(-dy_q) : unsigned'(dy_q);
          state_q <= StSum;
        end
        StSum: begin
          dsq_q     <= sqx_q + sqy_q;
          rt_rad_q  <= sqx_q + sqy_q;
          rt_rem_q  <= '0;
          rt_root_q <= '0;
          cnt_q     <= '0;
          if ((sqx_q + sqy_q) == '0) begin
            // coincident points: take the direction as (1,0)
            dist_q  <= '0;
            ux_q    <= signed'(UnitOne);
            uy_q    <= '0;
            state_q <= StIdle;
          end else begin
            state_q <= StRoot;
          end
        end
        StRoot: begin
          rt_rad_q  <= rt_rad_q << 2;
          rt_rem_q  <= rt_rem_nx;
          rt_root_q <= rt_root_nx;
          cnt_q     <= cnt_q + 1'b1;
          if (last_root) begin
            dist_q   <= rt_root_nx;
            dv_rem_q <= DistBits'(dvd_x >> UnitBits);
            dv_low_q <= dvd_x[UnitBits-1:0];
            dv_quo_q <= '0;
            cnt_q    <= '0;
            state_q  <= StDivX;
          end
        end
        StDivX: begin
          dv_rem_q <= dv_rem_nx;
          dv_low_q <= dv_low_q << 1;
          dv_quo_q <= dv_quo_nx;
          cnt_q    <= cnt_q + 1'b1;
          if (last_div) begin
            ux_q     <= dx_q[DeltaBits-1] ? -signed'(dv_clamp) : signed'(dv_clamp);
            dv_rem_q <= DistBits'(dvd_y >> UnitBits);
            dv_low_q <= dvd_y[UnitBits-1:0];
            dv_quo_q <= '0;
            cnt_q    <= '0;
            state_q  <= StDivY;
          end
        end
        StDivY: begin
          dv_rem_q <= dv_rem_nx;
          dv_low_q <= dv_low_q << 1;
          dv_quo_q <= dv_quo_nx;
          cnt_q    <= cnt_q + 1'b1;
          if (last_div) begin
            uy_q    <= dy_q[DeltaBits-1] ? -signed'(dv_clamp) : signed'(dv_clamp);
            cnt_q   <= '0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign geom_o.busy   = (state_q != StIdle);
  assign geom_o.dsq    = dsq_q;
  assign geom_o.dlen   = dist_q;
  assign geom_o.ux     = ux_q;
  assign geom_o.uy     = uy_q;
  assign geom_o.mid_x  = mid_x_q;
  assign geom_o.mid_y  = mid_y_q;
  assign geom_o.inf_en = en_q;
  assign geom_o.margin = margin_q;

endmodule
`default_nettype wire

[hw/rtl/ies_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ies_front: request intake
// Accepts a request, squares the cost, scales the major-axis random number
// and decides move_now, then hands the transaction to the queue.
// ----------------------------------------------------------------------------
module ies_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ies_in_if.sink              in_if,
  input  ies_pkg::ies_geom_t  geom_i,
  output logic                push_o,
  input  wire logic           push_ready_i,
  output ies_pkg::ies_item_t  item_o
);
  import ies_pkg::*;

  logic      valid_q;
  ies_item_t item_q;
  ies_item_t item_d;
  logic      take;

  // Classification of the incoming request
  logic signed [RandBits+CoordBits:0] u_prod;
  logic signed [DistBits:0]           diff;
  logic [DistBits:0]                  diff_mag;

  assign u_prod   = $signed(in_if.rand_u) * $signed({1'b0, in_if.best_cost});
  assign diff     = $signed({2'b00, in_if.best_cost}) - $signed({1'b0, geom_i.dlen});
  assign diff_mag = diff[DistBits] ? unsigned'(-diff) : unsigned'(diff);

  always_comb begin
    item_d.cost_sq  = {{CoordBits{1'b0}}, in_if.best_cost}
                    * {{CoordBits{1'b0}}, in_if.best_cost};
    item_d.pa       = u_prod[RandBits +: DeltaBits];
    item_d.rand_v   = in_if.rand_v;
    item_d.move_now = geom_i.inf_en && (diff_mag < {2'b00, geom_i.margin});
  end

  // Hold off while the geometry is recomputed or the stage cannot drain
  assign in_if.ready = !geom_i.busy && (!valid_q || push_ready_i);
  assign take        = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign push_o = valid_q && push_ready_i;
  assign item_o = item_q;

endmodule
`default_nettype wire

[hw/rtl/ies_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ies_fifo: front-to-back queue
// Short first-in first-out queue of classified transactions.
// ----------------------------------------------------------------------------
module ies_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  ies_pkg::ies_item_t  item_i,
  output logic                not_full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output ies_pkg::ies_item_t  item_o
);
  import ies_pkg::*;

  localparam int PtrBits = $clog2(FifoDepth);

  ies_item_t            store_q [FifoDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [PtrBits:0]     cnt_q;

  assign not_full_o = (cnt_q != (PtrBits+1)'(FifoDepth));
  assign valid_o    = (cnt_q != '0);
  assign item_o     = store_q[rd_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ies_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ies_back: sample datapath
// Pipelined minor-axis root (one bit per stage), minor scaling, rotation
// onto the start-goal direction, midpoint offset, saturation, result register.
// ----------------------------------------------------------------------------
module ies_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fifo_valid_i,
  input  ies_pkg::ies_item_t  item_i,
  output logic                pop_o,
  input  ies_pkg::ies_geom_t  geom_i,
  ies_out_if.source           out_if
);
  import ies_pkg::*;

  localparam int SqRemBits = RootBits + 2;

  typedef struct packed {
    logic signed [DeltaBits-1:0] pa;
    logic signed [RandBits-1:0]  rand_v;
    logic                        move_now;
    logic                        below;
  } side_t;

  logic out_v_q;
  logic adv;

  // Whole pipeline moves unless a finished result is still waiting
  assign adv   = !out_v_q || out_if.ready;
  assign pop_o = adv && fifo_valid_i;

  // Root stages; index 0 is the entry stage
  logic                  sq_v_q    [RootBits+1];
  logic [CostSqBits-1:0] sq_rad_q  [RootBits+1];
  logic [SqRemBits-1:0]  sq_rem_q  [RootBits+1];
  logic [RootBits-1:0]   sq_root_q [RootBits+1];
  side_t                 sq_side_q [RootBits+1];

  logic below;
  assign below = ({2'b00, item_i.cost_sq} < geom_i.dsq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= fifo_valid_i;
    end
  end

  // Entry: remove the focal distance, or force a zero minor axis
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rad_q[0]           <= below ? '0
                             : CostSqBits'({2'b00, item_i.cost_sq} - geom_i.dsq);
      sq_rem_q[0]           <= '0;
      sq_root_q[0]          <= '0;
      sq_side_q[0].pa       <= item_i.pa;
      sq_side_q[0].rand_v   <= item_i.rand_v;
      sq_side_q[0].move_now <= item_i.move_now;
      sq_side_q[0].below    <= below;
    end
  end

  for (genvar k = 0; k < RootBits; k++) begin : g_root
    logic [SqRemBits+1:0] rn, trial;
    logic                 ge;

    assign rn    = {sq_rem_q[k], sq_rad_q[k][CostSqBits-1 -: 2]};
    assign trial = {2'b00, sq_root_q[k], 2'b01};
    assign ge    = (rn >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
        sq_rem_q[k+1]  <= ge ? SqRemBits'(rn - trial) : SqRemBits'(rn);
        sq_root_q[k+1] <= {sq_root_q[k][RootBits-2:0], ge};
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  // Scale the minor-axis random number
  logic                              qs_v_q;
  logic signed [DeltaBits-1:0]       qs_pa_q, qs_qb_q;
  logic                              qs_move_q, qs_below_q;
  logic signed [RandBits+RootBits:0] v_prod;

  assign v_prod = $signed(sq_side_q[RootBits].rand_v)
                * $signed({1'b0, sq_root_q[RootBits]});

  // Rotate: four products
  logic                        rp_v_q;
  logic signed [ProdBits-1:0]  pa_ux_q, qb_uy_q, pa_uy_q, qb_ux_q;
  logic                        rp_move_q, rp_below_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_v_q  <= 1'b0;
      rp_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      qs_v_q  <= sq_v_q[RootBits];
      rp_v_q  <= qs_v_q;
      out_v_q <= rp_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qs_pa_q    <= sq_side_q[RootBits].pa;
      qs_qb_q    <= v_prod[RandBits +: DeltaBits];
      qs_move_q  <= sq_side_q[RootBits].move_now;
      qs_below_q <= sq_side_q[RootBits].below;
      pa_ux_q    <= qs_pa_q * geom_i.ux;
      qb_uy_q    <= qs_qb_q * geom_i.uy;
      pa_uy_q    <= qs_pa_q * geom_i.uy;
      qb_ux_q    <= qs_qb_q * geom_i.ux;
      rp_move_q  <= qs_move_q;
      rp_below_q <= qs_below_q;
    end
  end

  // Combine, offset to the midpoint and saturate
  function automatic logic signed [CoordBits-1:0] sat_coord(logic signed [SumBits-1:0] v);
    logic [SumBits-CoordBits:0] top;
    top = v[SumBits-1:CoordBits-1];
    if ((top == '0) || (top == '1)) begin
      return v[CoordBits-1:0];
    end else if (v[SumBits-1]) begin
      return {1'b1, {(CoordBits-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordBits-1){1'b1}}};
    end
  endfunction

  logic signed [ProdBits:0]  rot_x, rot_y;
  logic signed [SumBits-1:0] sum_x, sum_y;

  assign rot_x = {pa_ux_q[ProdBits-1], pa_ux_q} - {qb_uy_q[ProdBits-1], qb_uy_q};
  assign rot_y = {pa_uy_q[ProdBits-1], pa_uy_q} + {qb_ux_q[ProdBits-1], qb_ux_q};
  assign sum_x = SumBits'($signed(rot_x[ProdBits:UnitFrac]))
               + SumBits'($signed(geom_i.mid_x));
  assign sum_y = SumBits'($signed(rot_y[ProdBits:UnitFrac]))
               + SumBits'($signed(geom_i.mid_y));

  logic signed [CoordBits-1:0] px_q, py_q;
  logic                        move_q, below_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q    <= sat_coord(sum_x);
      py_q    <= sat_coord(sum_y);
      move_q  <= rp_move_q;
      below_q <= rp_below_q;
    end
  end

  assign out_if.valid               = out_v_q;
  assign out_if.sample_x            = px_q;
  assign out_if.sample_y            = py_q;
  assign out_if.move_now            = move_q;
  assign out_if.cost_below_distance = below_q;

endmodule
`default_nettype wire

[hw/rtl/informed_ellipse_sampler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// informed_ellipse_sampler: informed sampling ellipse mapper
// Maps a best cost and two random numbers to a point in the ellipse with
// foci at start and goal, plus the move_now and cost-below-distance flags.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  in_if   | in  | valid/ready   | best_cost, rand_u, rand_v
//  out_if  | out | valid/ready   | sample_x, sample_y, move_now,
//          |     |               | cost_below_distance
//  cfg     | in  | cfg_we_i only | cfg_idx_i, cfg_data_i
//
//  One transaction per cycle unless a recompute or stall holds intake. Stages:
//  front register, queue, root entry, 24 root stages, scale, rotate, result.
//  Each register write starts a geometry recompute in a shared bit-serial
//  root/divide unit; in_if.ready stays low until it completes.
//  Reset needs no recompute; geometry resets to the values of the reset map.
//  A stalled result stalls the back pipeline; the queue buffers until full.
// ----------------------------------------------------------------------------
module informed_ellipse_sampler (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ies_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [ies_pkg::CoordBits-1:0]   cfg_data_i,
  ies_in_if.sink                               in_if,
  ies_out_if.source                            out_if
);
  import ies_pkg::*;

  ies_geom_t geom;
  ies_item_t push_item, pop_item;
  logic      push, not_full, fifo_valid, pop;

  ies_geom u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  ies_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .geom_i       (geom),
    .push_o       (push),
    .push_ready_i (not_full),
    .item_o       (push_item)
  );

  ies_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (push_item),
    .not_full_o (not_full),
    .pop_i      (pop),
    .valid_o    (fifo_valid),
    .item_o     (pop_item)
  );

  ies_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .geom_i       (geom),
    .out_if       (out_if)
  );

endmodule
`default_nettype wire

[hw/rtl/ies_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ies_checker: port-level checks
// Watches the sampler's ports for stall, reset and recompute behaviour.
// ----------------------------------------------------------------------------
module ies_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          in_ready_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [ies_pkg::CoordBits-1:0] sample_x_i,
  input  wire logic [ies_pkg::CoordBits-1:0] sample_y_i
);
  import ies_pkg::*;

  // A register write always starts a recompute that blocks intake
  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("intake open right after a register write");

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Stalled result keeps its sample
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_x_i) && $stable(sample_y_i))
    else $error("sample changed while stalled");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered straight after reset");

endmodule

bind informed_ellipse_sampler ies_checker u_ies_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .sample_x_i  (out_if.sample_x),
  .sample_y_i  (out_if.sample_y)
);
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: informed ellipse sampler testbench
// Drives cost and random requests, predicts most samples with a bit-exact
// fixed-point model of the ellipse mapping, and checks results in order.
// ----------------------------------------------------------------------------
module tb;
  import ies_pkg::*;

  localparam int Latency  = 100;
  localparam int WdgLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [CoordBits-1:0] cfg_data_i = '0;

  ies_in_if  in_if ();
  ies_out_if out_if ();

  informed_ellipse_sampler u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic [CoordBits-1:0] sx;
    logic [CoordBits-1:0] sy;
    logic                 mv;
    logic                 below;
  } sample_t;

  typedef struct {
    logic [CoordBits-1:0] cost;
    logic [RandBits-1:0]  u;
    logic [RandBits-1:0]  v;
    bit                   known;
    sample_t              res;
  } req_row_t;

  // Shadow copy of the registers
  logic [CoordBits-1:0] sh_sx, sh_sy, sh_gx, sh_gy, sh_margin;
  logic                 sh_en;

  sample_t samples_due[$];
  int      errors = 0;
  int      wdg = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  bit      hold_off = 1'b0;

  // Floor square root of a 128-bit value
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0]  root;
    logic [129:0] rem;
    logic [129:0] trial;
    root = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | 130'((n >> (2 * i)) & 128'd3);
      root = root << 1;
      trial = 130'({root, 1'b1});
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic longint dir_comp(longint delta, longint dlen);
    longint mag;
    longint q;
    mag = (delta < 0) ? -delta : delta;
    q = (mag <<< UnitFrac) / dlen;
    if (q > 65536) q = 65536;
    return (delta < 0) ? -q : q;
  endfunction

  function automatic logic signed [CoordBits-1:0] clamp_coord(logic signed [127:0] v);
    if (v > 128'sd8388607) return 24'sh7fffff;
    if (v < -128'sd8388608) return 24'sh800000;
    return v[CoordBits-1:0];
  endfunction

  function automatic sample_t ellipse_point(logic [CoordBits-1:0] cost_i,
                                            logic [RandBits-1:0] u_i,
                                            logic [RandBits-1:0] v_i);
    sample_t r;
    longint sx, sy, gx, gy, dx, dy, dlen, minor, diff, ux, uy, pa, qb, mx, my;
    logic [127:0] dsq, csq;
    logic signed [127:0] tx, ty;
    sx = longint'($signed(sh_sx));
    sy = longint'($signed(sh_sy));
    gx = longint'($signed(sh_gx));
    gy = longint'($signed(sh_gy));
    dx = gx - sx;
    dy = gy - sy;
    dsq = 128'(dx * dx) + 128'(dy * dy);
    csq = 128'(cost_i) * 128'(cost_i);
    dlen = longint'(floor_root(dsq));
    r.below = csq < dsq;
    minor = r.below ? 0 : longint'(floor_root(csq - dsq));
    diff = longint'(cost_i) - dlen;
    if (diff < 0) diff = -diff;
    r.mv = sh_en && (diff < longint'(sh_margin));
    if (dlen == 0) begin
      ux = 65536;
      uy = 0;
    end else begin
      ux = dir_comp(dx, dlen);
      uy = dir_comp(dy, dlen);
    end
    pa = (longint'($signed(u_i)) * longint'(cost_i)) >>> RandBits;
    qb = (longint'($signed(v_i)) * minor) >>> RandBits;
    mx = (sx + gx) >>> 1;
    my = (sy + gy) >>> 1;
    tx = 128'(mx) + ((128'(pa) * 128'(ux) - 128'(qb) * 128'(uy)) >>> UnitFrac);
    ty = 128'(my) + ((128'(pa) * 128'(uy) + 128'(qb) * 128'(ux)) >>> UnitFrac);
    r.sx = clamp_coord(tx);
    r.sy = clamp_coord(ty);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [CoordBits-1:0] got,
                                 logic [CoordBits-1:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  // Write a register while the sampler is idle; keep the shadow in step
  task automatic write_reg(cfg_reg_e idx, logic [CoordBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegStartX: sh_sx = val;
      RegStartY: sh_sy = val;
      RegGoalX:  sh_gx = val;
      RegGoalY:  sh_gy = val;
      RegInfEn:  sh_en = val[0];
      RegMargin: sh_margin = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  // Offer one request and hold it until the transaction completes
  task automatic send_req(logic [CoordBits-1:0] c, logic [RandBits-1:0] u,
                          logic [RandBits-1:0] v, bit known, sample_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.best_cost <= c;
    in_if.rand_u <= u;
    in_if.rand_v <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    samples_due.insert(samples_due.size(), known ? want : ellipse_point(c, u, v));
  endtask

  task automatic rand_req();
    logic [CoordBits-1:0] c;
    case ($urandom_range(3))
      0: c = CoordBits'($urandom);
      1: c = CoordBits'($urandom_range(200000));
      2: c = CoordBits'($urandom_range(4096));
      default: c = $urandom_range(1) ? '1 : '0;
    endcase
    send_req(c, RandBits'($urandom), RandBits'($urandom), 1'b0, '0);
  endtask

  task automatic rand_geometry(bit wide);
    write_reg(RegStartX, wide ? CoordBits'($urandom) : CoordBits'($urandom_range(60000)));
    write_reg(RegStartY, wide ? CoordBits'($urandom) : CoordBits'($urandom_range(60000)));
    write_reg(RegGoalX, wide ? CoordBits'($urandom) : CoordBits'($urandom_range(60000)));
    write_reg(RegGoalY, wide ? CoordBits'($urandom) : CoordBits'($urandom_range(60000)));
    write_reg(RegInfEn, CoordBits'($urandom_range(1)));
    write_reg(RegMargin, CoordBits'($urandom));
  endtask

  // Receiver: random stalls, a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (samples_due.size() == 0) begin
        report_mismatch("unexpected sample", out_if.sample_x, '0);
      end else begin
        sample_t w;
        w = samples_due.pop_front();
        if (out_if.sample_x !== w.sx) report_mismatch("sample_x", out_if.sample_x, w.sx);
        if (out_if.sample_y !== w.sy) report_mismatch("sample_y", out_if.sample_y, w.sy);
        if (out_if.move_now !== w.mv)
          report_mismatch("move_now", CoordBits'(out_if.move_now), CoordBits'(w.mv));
        if (out_if.cost_below_distance !== w.below)
          report_mismatch("below", CoordBits'(out_if.cost_below_distance),
                          CoordBits'(w.below));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      wdg <= 0;
    end else if (wdg >= WdgLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      wdg <= wdg + 1;
    end
  end

  // Directed table: reset geometry gives the origin, plain extremes
  req_row_t rows[] = '{
    '{24'd0, 16'h0000, 16'h0000, 1'b1, '{24'd0, 24'd0, 1'b0, 1'b0}},
    '{24'd512, 16'h0000, 16'h0000, 1'b1, '{24'd0, 24'd0, 1'b0, 1'b0}},
    '{24'hffffff, 16'h7fff, 16'h7fff, 1'b0, '0},
    '{24'hffffff, 16'h8000, 16'h8000, 1'b0, '0},
    '{24'hffffff, 16'h8000, 16'h7fff, 1'b0, '0},
    '{24'd1000, 16'h4000, 16'hc000, 1'b0, '0},
    '{24'd1, 16'hffff, 16'h0001, 1'b0, '0},
    '{24'h800000, 16'h5555, 16'haaaa, 1'b0, '0}
  };

  initial begin
    in_if.valid = 1'b0;
    in_if.best_cost = '0;
    in_if.rand_u = '0;
    in_if.rand_v = '0;
    sh_sx = '0; sh_sy = '0; sh_gx = '0; sh_gy = '0; sh_en = 1'b0;
    sh_margin = MarginReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset map, then extreme geometries
    foreach (rows[i]) send_req(rows[i].cost, rows[i].u, rows[i].v, rows[i].known, rows[i].res);
    drain();
    write_reg(RegInfEn, 24'd1);
    write_reg(RegGoalX, 24'd2560);
    foreach (rows[i]) send_req(rows[i].cost, rows[i].u, rows[i].v, 1'b0, '0);
    send_req(24'd2560, 16'h7fff, 16'h7fff, 1'b0, '0);
    send_req(24'd2559, 16'h7fff, 16'h7fff, 1'b0, '0);
    drain();
    write_reg(RegStartX, 24'h800000);
    write_reg(RegStartY, 24'h7fffff);
    write_reg(RegGoalX, 24'h7fffff);
    write_reg(RegGoalY, 24'h800000);
    write_reg(RegMargin, 24'hffffff);
    foreach (rows[i]) send_req(rows[i].cost, rows[i].u, rows[i].v, 1'b0, '0);
    drain();
    write_reg(RegMargin, 24'd0);
    write_reg(RegGoalY, 24'h7fffff);
    write_reg(RegGoalX, 24'h800000);
    send_req(24'hffffff, 16'h7fff, 16'h8000, 1'b0, '0);
    send_req(24'd0, 16'h8000, 16'h7fff, 1'b0, '0);
    drain();

    // Random phases across idling profiles
    for (int ph = 0; ph < 10; ph++) begin
      rand_geometry(ph % 3 == 0);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 4) begin
        // Hold the receiver off so the sampler fills and stalls intake
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
          repeat (110) rand_req();
        join
      end
      repeat (110) rand_req();
      if (ph == 6) begin
        // Pause the sender until every sample is back
        in_if.valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge clk_i);
        repeat (5) rand_req();
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
